/* rtl/sudc_pkg.sv */
// ----------------------------------------------------------------------------
// sudc_pkg: shared types, constants and table generators
// Holds the configuration record, the lane control group, the gain word
// handed from the gain path to the lanes, and the log2/exp2 table functions.
// ----------------------------------------------------------------------------
package sudc_pkg;

  // Default sizes.
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int DB_TABLE_BITS_DEF = 8;
  localparam int DB_TABLE_BITS_MAX = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_THR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_SLOPE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UP_SLOPE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_GAIN  = 3'd7;

  // Fixed-point constants.
  localparam int          MANT_W       = 31;          // exp2 mantissa, Q1.30
  localparam int          SHIFT_W      = 6;           // output shift, 21..40
  localparam int          EXP_W        = 21;          // Q16 log2 gain, signed
  localparam logic [18:0] DB_PER_LOG2  = 19'd394566;  // 20*log10(2), Q16
  localparam logic [13:0] LOG2_PER_DB  = 14'd10885;   // log2(10)/20, Q16
  localparam logic [12:0] CHANGE_LIMIT = 13'd6144;    // 24 dB in Q8.8
  localparam logic [16:0] DEPTH_ONE    = 17'h10000;

  typedef struct packed {
    logic        [15:0] att_coeff;
    logic        [15:0] rel_coeff;
    logic signed [15:0] down_thr;
    logic signed [15:0] up_thr;
    logic        [15:0] down_slope;
    logic        [15:0] up_slope;
    logic        [16:0] depth;
    logic signed [13:0] band_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    att_coeff:  16'd64881,
    rel_coeff:  16'd65470,
    down_thr:   -16'sd4608,
    up_thr:     -16'sd9216,
    down_slope: 16'd49152,
    up_slope:   16'd39322,
    depth:      17'd65536,
    band_gain:  14'sd0
  };

  typedef struct packed {
    logic load;      // take a new sample and its peak
    logic env_mul;   // form the envelope step product
    logic env_upd;   // add the rounded step to the envelope
    logic out_mul;   // multiply the sample by the gain mantissa
  } lane_ctrl_t;

  typedef struct packed {
    logic [MANT_W-1:0]  mant;
    logic [SHIFT_W-1:0] shift;
  } gain_t;

  // Integer square root, used only while building the exp2 table.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bw;
    logic [63:0] rem;
    r   = '0;
    bw  = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (bw > rem) bw = bw >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bw != 64'd0) begin
        if (rem >= r + bw) begin
          rem = rem - (r + bw);
          r   = (r >> 1) + bw;
        end else begin
          r = r >> 1;
        end
        bw = bw >> 2;
      end
    end
    return r;
  endfunction

  // log2(1 + i/2^tb) in Q0.16, by repeated squaring.
  function automatic logic [15:0] log_entry(input int i, input int tb);
    logic [63:0] x;
    logic [15:0] y;
    x = (64'd1 << 30) + (64'(i) << (30 - tb));
    y = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      y = y << 1;
      if (x >= (64'd1 << 31)) begin
        y[0] = 1'b1;
        x    = x >> 1;
      end
    end
    return y;
  endfunction

  // 2^(i/2^tb) in Q1.30, as a product of repeated square roots of two.
  function automatic logic [MANT_W-1:0] exp_entry(input int i, input int tb);
    logic [63:0] root [DB_TABLE_BITS_MAX+1];
    logic [63:0] v;
    root[0] = 64'd1 << 31;
    for (int k = 1; k <= DB_TABLE_BITS_MAX; k++) begin
      root[k] = (k <= tb) ? isqrt64(root[k-1] << 30) : 64'd0;
    end
    v = 64'd1 << 30;
    for (int k = 0; k < DB_TABLE_BITS_MAX; k++) begin
      if (k < tb && ((i >> k) & 1) == 1) v = (v * root[tb-k]) >> 30;
    end
    return v[MANT_W-1:0];
  endfunction

endpackage

/* rtl/sudc_lane.sv */
// ----------------------------------------------------------------------------
// sudc_lane: one channel of the compressor
// Peak detection, attack/release envelope follower, and the final gain
// multiply with rounding and saturation for one sample channel.
// ----------------------------------------------------------------------------
module sudc_lane #(
  parameter int SAMPLE_BITS = sudc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sudc_pkg::lane_ctrl_t         ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [15:0]                  att_coeff_i,
  input  logic [15:0]                  rel_coeff_i,
  input  sudc_pkg::gain_t              gain_i,
  output logic [SAMPLE_BITS-2:0]       env_o,
  output logic [SAMPLE_BITS-1:0]       result_o
);

  localparam int AW  = SAMPLE_BITS - 1;          // magnitude width
  localparam int PEW = SAMPLE_BITS + 18;         // envelope step product
  localparam int PW  = SAMPLE_BITS + sudc_pkg::MANT_W;

  localparam logic [sudc_pkg::SHIFT_W-1:0] SHIFT_ONE = 1;

  logic [SAMPLE_BITS-1:0]  x_q;
  logic [AW-1:0]           peak_q;
  logic [AW-1:0]           env_q;
  logic signed [PEW-1:0]   step_q;
  logic [PW-1:0]           gprod_q;

  logic [SAMPLE_BITS-1:0]  s_mag;
  logic [AW-1:0]           peak_d;
  logic [15:0]             coeff;
  logic [16:0]             cw;
  logic signed [SAMPLE_BITS-1:0] diff;
  logic signed [PEW-1:0]   cw_s;
  logic signed [PEW-1:0]   diff_s;
  logic signed [PEW-1:0]   step_d;
  logic signed [PEW-1:0]   upd;
  logic [AW-1:0]           env_d;
  logic                    x_neg;
  logic [SAMPLE_BITS-1:0]  x_mag;
  logic [PW-1:0]           gprod_d;
  logic [PW:0]             rnd;
  logic [PW:0]             lim;
  logic [SAMPLE_BITS-1:0]  out_mag;

  // The most negative sample has no positive twin: its peak is clipped.
  always_comb begin
    s_mag  = sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_i) : SAMPLE_BITS'(sample_i);
    peak_d = s_mag[AW] ? {AW{1'b1}} : s_mag[AW-1:0];
  end

  // env' = env + ((65536 - c) * (peak - env) + 2^15) >>> 16, the same value
  // as the weighted sum of envelope and peak, but with a single multiply.
  always_comb begin
    coeff  = (peak_q > env_q) ? att_coeff_i : rel_coeff_i;
    cw     = 17'h10000 - {1'b0, coeff};
    diff   = $signed({1'b0, peak_q}) - $signed({1'b0, env_q});
    cw_s   = signed'(PEW'(cw));
    diff_s = PEW'(diff);
    step_d = cw_s * diff_s;
    upd    = (step_q + PEW'(32768)) >>> 16;
    env_d  = env_q + upd[AW-1:0];
  end

  always_comb begin
    x_neg   = x_q[SAMPLE_BITS-1];
    x_mag   = x_neg ? (~x_q + SAMPLE_BITS'(1)) : x_q;
    gprod_d = PW'(x_mag) * PW'(gain_i.mant);
    rnd     = ({1'b0, gprod_q} + ((PW+1)'(1) << (gain_i.shift - SHIFT_ONE)))
              >> gain_i.shift;
    lim     = x_neg ? ((PW+1)'(1) << AW) : (((PW+1)'(1) << AW) - (PW+1)'(1));
    out_mag = (rnd > lim) ? lim[SAMPLE_BITS-1:0] : rnd[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (ctrl_i.env_upd) begin
      env_q <= env_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q    <= sample_i;
      peak_q <= peak_d;
    end
    if (ctrl_i.env_mul) step_q  <= step_d;
    if (ctrl_i.out_mul) gprod_q <= gprod_d;
  end

  assign env_o    = env_q;
  assign result_o = x_neg ? (~out_mag + SAMPLE_BITS'(1)) : out_mag;

endmodule

/* rtl/sudc_gain.sv */
// ----------------------------------------------------------------------------
// sudc_gain: shared gain computer
// Merges the two lane envelopes, converts the level to dB, applies the
// downward and upward curves, depth and band gain, and looks up the linear
// gain mantissa and shift, one step per cycle.
// ----------------------------------------------------------------------------
module sudc_gain #(
  parameter int SAMPLE_BITS   = sudc_pkg::SAMPLE_BITS_DEF,
  parameter int DB_TABLE_BITS = sudc_pkg::DB_TABLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  sudc_pkg::cfg_t         cfg_i,
  input  logic [SAMPLE_BITS-2:0] env_l_i,
  input  logic [SAMPLE_BITS-2:0] env_r_i,
  output logic                   done_o,
  output sudc_pkg::gain_t        gain_o
);

  localparam int AW  = SAMPLE_BITS - 1;
  localparam int TAB = 1 << DB_TABLE_BITS;
  localparam int K   = $clog2(AW);        // normalize steps
  localparam int KW  = $clog2(K);
  localparam int LZW = K;
  localparam int NGW = K + 17;            // Q16 log2 below full scale
  localparam int LPW = NGW + 19;
  localparam int LMW = LPW - 24;          // level magnitude, Q8.8
  localparam int DFW = LMW + 2;           // threshold minus level
  localparam int DMW = DFW - 1;
  localparam int CPW = DMW + 16;
  localparam int EW  = sudc_pkg::EXP_W;

  localparam logic [AW-1:0] FLOOR_RAW =
    AW'(((64'd1 << (SAMPLE_BITS - 1)) + 64'd50000) / 64'd100000);
  localparam logic [AW-1:0] FLOOR_LVL = (FLOOR_RAW == '0) ? AW'(1) : FLOOR_RAW;

  typedef enum logic [3:0] {
    G_IDLE, G_NORM, G_LOG, G_NEG, G_LVL, G_DIFF, G_CHG, G_SCALE, G_EXP, G_ROM
  } gstate_e;

  logic [15:0]                   log_rom [TAB];
  logic [sudc_pkg::MANT_W-1:0]   exp_rom [TAB];

  for (genvar g = 0; g < TAB; g++) begin : g_rom
    localparam logic [15:0] LOG_V = sudc_pkg::log_entry(g, DB_TABLE_BITS);
    localparam logic [sudc_pkg::MANT_W-1:0] EXP_V = sudc_pkg::exp_entry(g, DB_TABLE_BITS);
    assign log_rom[g] = LOG_V;
    assign exp_rom[g] = EXP_V;
  end

  gstate_e                      state_q;
  logic [AW-1:0]                norm_q;
  logic [KW-1:0]                k_q;
  logic [LZW-1:0]               lz_q;
  logic [15:0]                  logv_q;
  logic [NGW-1:0]               neg_q;
  logic [LMW-1:0]               lmag_q;
  logic                         dneg_q;
  logic [DMW-1:0]               dmag_q;
  logic [15:0]                  slope_q;
  logic [12:0]                  cmag_q;
  logic signed [15:0]           total_q;
  logic signed [EW-1:0]         e_q;
  logic [sudc_pkg::MANT_W-1:0]  mant_q;
  logic [sudc_pkg::SHIFT_W-1:0] shift_q;

  logic [AW:0]                  env_sum;
  logic [AW-1:0]                avg;
  logic [AW-1:0]                avg_fl;
  logic [LZW-1:0]               step_w;
  logic [AW-1:0]                top_mask;
  logic                         top_zero;
  logic [NGW-1:0]               neg_d;
  logic [LPW-1:0]               lvl_sum;
  logic signed [DFW-1:0]        dd;
  logic signed [DFW-1:0]        ud;
  logic signed [DFW-1:0]        dd_abs;
  logic [CPW-1:0]               chg_sum;
  logic [CPW-16-1:0]            cm;
  logic [16:0]                  depth_sat;
  logic [29:0]                  sc_sum;
  logic signed [15:0]           sm_s;
  logic signed [15:0]           total_d;
  logic [15:0]                  tmag;
  logic [29:0]                  ex_sum;
  logic [EW-1:0]                em;
  logic [6:0]                   shift_w;

  always_comb begin
    env_sum  = {1'b0, env_l_i} + {1'b0, env_r_i};
    avg      = env_sum[AW:1];
    avg_fl   = (avg < FLOOR_LVL) ? FLOOR_LVL : avg;
    step_w   = LZW'(1) << k_q;
    top_mask = ~({AW{1'b1}} >> step_w);
    top_zero = (norm_q & top_mask) == '0;
    // Leading one at bit p gives (S - 1 - p) = lz + 1 whole octaves below.
    neg_d    = ((NGW'(lz_q) + NGW'(1)) << 16) - NGW'(logv_q);
    lvl_sum  = LPW'(neg_q) * LPW'(sudc_pkg::DB_PER_LOG2) + (LPW'(1) << 23);
    dd       = DFW'(cfg_i.down_thr) + signed'(DFW'(lmag_q));
    ud       = DFW'(cfg_i.up_thr) + signed'(DFW'(lmag_q));
    dd_abs   = -dd;
    chg_sum  = CPW'(dmag_q) * CPW'(slope_q) + CPW'(32768);
    cm       = chg_sum[CPW-1:16];
    depth_sat = (cfg_i.depth > sudc_pkg::DEPTH_ONE) ? sudc_pkg::DEPTH_ONE : cfg_i.depth;
    sc_sum   = 30'(cmag_q) * 30'(depth_sat) + 30'd32768;
    sm_s     = signed'(16'(sc_sum[28:16]));
    total_d  = (dneg_q ? -sm_s : sm_s) + 16'(cfg_i.band_gain);
    tmag     = total_q[15] ? 16'(-total_q) : 16'(total_q);
    ex_sum   = 30'(tmag) * 30'(sudc_pkg::LOG2_PER_DB) + 30'd128;
    em       = EW'(ex_sum[29:8]);
    shift_w  = 7'd30 - {{2{e_q[EW-1]}}, e_q[EW-1:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      norm_q  <= '0;
      k_q     <= '0;
      lz_q    <= '0;
      logv_q  <= '0;
      neg_q   <= '0;
      lmag_q  <= '0;
      dneg_q  <= 1'b0;
      dmag_q  <= '0;
      slope_q <= '0;
      cmag_q  <= '0;
      total_q <= '0;
      e_q     <= '0;
      mant_q  <= '0;
      shift_q <= '0;
    end else begin
      case (state_q)
        G_IDLE: begin
          if (start_i) begin
            norm_q  <= avg_fl;
            k_q     <= KW'(K - 1);
            lz_q    <= '0;
            state_q <= G_NORM;
          end
        end
        G_NORM: begin
          if (top_zero) begin
            norm_q <= norm_q << step_w;
            lz_q   <= lz_q + step_w;
          end
          if (k_q == '0) state_q <= G_LOG;
          else           k_q     <= k_q - KW'(1);
        end
        G_LOG: begin
          logv_q  <= log_rom[norm_q[AW-2 -: DB_TABLE_BITS]];
          state_q <= G_NEG;
        end
        G_NEG: begin
          neg_q   <= neg_d;
          state_q <= G_LVL;
        end
        G_LVL: begin
          lmag_q  <= lvl_sum[LPW-1:24];
          state_q <= G_DIFF;
        end
        G_DIFF: begin
          // Downward curve wins when both thresholds are crossed.
          if (dd < 0) begin
            dneg_q  <= 1'b1;
            dmag_q  <= dd_abs[DMW-1:0];
            slope_q <= cfg_i.down_slope;
          end else if (ud > 0) begin
            dneg_q  <= 1'b0;
            dmag_q  <= ud[DMW-1:0];
            slope_q <= cfg_i.up_slope;
          end else begin
            dneg_q  <= 1'b0;
            dmag_q  <= '0;
            slope_q <= cfg_i.up_slope;
          end
          state_q <= G_CHG;
        end
        G_CHG: begin
          cmag_q  <= (cm > (CPW-16)'(sudc_pkg::CHANGE_LIMIT)) ?
                     sudc_pkg::CHANGE_LIMIT : cm[12:0];
          state_q <= G_SCALE;
        end
        G_SCALE: begin
          total_q <= total_d;
          state_q <= G_EXP;
        end
        G_EXP: begin
          e_q     <= total_q[15] ? -signed'(em) : signed'(em);
          state_q <= G_ROM;
        end
        G_ROM: begin
          mant_q  <= exp_rom[e_q[15 -: DB_TABLE_BITS]];
          shift_q <= shift_w[sudc_pkg::SHIFT_W-1:0];
          state_q <= G_IDLE;
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign done_o       = (state_q == G_ROM);
  assign gain_o.mant  = mant_q;
  assign gain_o.shift = shift_q;

endmodule

/* rtl/stereo_upward_downward_compressor.sv */
// ----------------------------------------------------------------------------
// stereo_upward_downward_compressor: stereo upward/downward compressor
// A request passes the envelope multiply and update, the shared gain
// sequencer and the output multiply and rounding before m_axis_tvalid
// rises; no new request is taken until its result is in the output register.
// Reset (rst_ni low, asynchronous) clears both envelopes, loads the default
// register values and empties the output register.
// ----------------------------------------------------------------------------
module stereo_upward_downward_compressor #(
  parameter  int SAMPLE_BITS   = sudc_pkg::SAMPLE_BITS_DEF,
  parameter  int DB_TABLE_BITS = sudc_pkg::DB_TABLE_BITS_DEF,
  localparam int TDATA_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream; tdata: left_in, right_in, zero pad.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [TDATA_W-1:0]                s_axis_tdata,
  // Output stream; tdata: left_out, right_out, zero pad.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [TDATA_W-1:0]                m_axis_tdata,
  // Register write port.
  input  logic                              cfg_we_i,
  input  logic [sudc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sudc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int AW = SAMPLE_BITS - 1;

  // The sequencer walks one request through the lanes and the gain path.
  typedef enum logic [2:0] {
    ST_IDLE, ST_ENV_MUL, ST_ENV_UPD, ST_GAIN_GO, ST_GAIN_WAIT, ST_OUT_MUL, ST_OUT_RND
  } state_e;

  state_e                 state_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_l_q;
  logic [SAMPLE_BITS-1:0] out_r_q;
  sudc_pkg::cfg_t         cfg_q;

  sudc_pkg::lane_ctrl_t   lane_ctrl;
  sudc_pkg::gain_t        gain;
  logic                   gain_start;
  logic                   gain_done;
  logic                   in_take;
  logic                   out_load;
  logic [AW-1:0]          env_l;
  logic [AW-1:0]          env_r;
  logic [SAMPLE_BITS-1:0] res_l;
  logic [SAMPLE_BITS-1:0] res_r;

  // Configuration registers. Writes must come only while the block is idle,
  // lest a value change in the middle of a request; not enforced by the block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sudc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sudc_pkg::REG_ATTACK:     cfg_q.att_coeff  <= cfg_wdata_i[15:0];
        sudc_pkg::REG_RELEASE:    cfg_q.rel_coeff  <= cfg_wdata_i[15:0];
        sudc_pkg::REG_DOWN_THR:   cfg_q.down_thr   <= signed'(cfg_wdata_i[15:0]);
        sudc_pkg::REG_UP_THR:     cfg_q.up_thr     <= signed'(cfg_wdata_i[15:0]);
        sudc_pkg::REG_DOWN_SLOPE: cfg_q.down_slope <= cfg_wdata_i[15:0];
        sudc_pkg::REG_UP_SLOPE:   cfg_q.up_slope   <= cfg_wdata_i[15:0];
        sudc_pkg::REG_DEPTH:      cfg_q.depth      <= cfg_wdata_i;
        sudc_pkg::REG_BAND_GAIN:  cfg_q.band_gain  <= signed'(cfg_wdata_i[13:0]);
        default: ;
      endcase
    end
  end

  // A request is taken only between items. The output register sits apart,
  // so the next request can enter while the previous result waits.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // The final rounding step lands in the output register once it is free.
  assign out_load = (state_q == ST_OUT_RND) && (!out_valid_q || m_axis_tready);

  always_comb begin
    lane_ctrl.load    = in_take;
    lane_ctrl.env_mul = (state_q == ST_ENV_MUL);
    lane_ctrl.env_upd = (state_q == ST_ENV_UPD);
    lane_ctrl.out_mul = (state_q == ST_OUT_MUL);
    gain_start        = (state_q == ST_GAIN_GO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_l_q     <= '0;
      out_r_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE:      if (in_take) state_q <= ST_ENV_MUL;
        ST_ENV_MUL:   state_q <= ST_ENV_UPD;
        ST_ENV_UPD:   state_q <= ST_GAIN_GO;
        ST_GAIN_GO:   state_q <= ST_GAIN_WAIT;
        ST_GAIN_WAIT: if (gain_done) state_q <= ST_OUT_MUL;
        ST_OUT_MUL:   state_q <= ST_OUT_RND;
        ST_OUT_RND:   if (out_load) state_q <= ST_IDLE;
        default:      state_q <= ST_IDLE;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
        out_l_q     <= res_l;
        out_r_q     <= res_r;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'({out_r_q, out_l_q});

  // Left and right lanes: each keeps its own envelope and applies the
  // common gain to its own sample.
  sudc_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_l (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl),
    .sample_i    (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
    .att_coeff_i (cfg_q.att_coeff),
    .rel_coeff_i (cfg_q.rel_coeff),
    .gain_i      (gain),
    .env_o       (env_l),
    .result_o    (res_l)
  );

  sudc_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_r (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl),
    .sample_i    (signed'(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .att_coeff_i (cfg_q.att_coeff),
    .rel_coeff_i (cfg_q.rel_coeff),
    .gain_i      (gain),
    .env_o       (env_r),
    .result_o    (res_r)
  );

  // The gain path merges both envelopes into one stereo-linked gain.
  sudc_gain #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .DB_TABLE_BITS (DB_TABLE_BITS)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gain_start),
    .cfg_i   (cfg_q),
    .env_l_i (env_l),
    .env_r_i (env_r),
    .done_o  (gain_done),
    .gain_o  (gain)
  );

endmodule
